// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/tmtw_pkg.sv
// ---------------------------------------------------------------------------
// tmtw_pkg
// Screen geometry, item formats and codes for the text mode terminal writer.
// ---------------------------------------------------------------------------
package tmtw_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
    localparam int MOVE_CELLS  = SCREEN_COLS * (SCREEN_ROWS - 1);

    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELL_TOTAL);
    localparam int CUR_W  = $clog2(CELL_TOTAL + 1);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int POS_W  = 11;

    localparam logic [1:0] FUNC_PRINT = 2'd0;
    localparam logic [1:0] FUNC_PUT   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] CLR_ATTR_RST = 8'd15;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [4:0] row;
        logic [6:0] col;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] cursor_pos;
        logic [7:0]       read_char;
        logic [7:0]       read_attr;
        logic             scrolled;
        logic             out_of_range;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: design/text_mode_terminal_writer_core.sv
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_core
// 80x25 character/attribute screen buffer with a linear cursor.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, i_in_item) takes one command item:
// print char, put at row/col, clear screen or read cell. Every item gives one
// result item on the output channel (o_out_valid / i_out_ready, o_out_item).
// The config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the clear
// attribute; it is always ready and should be written only while idle.
// Each item passes S_EXEC and S_DONE; an on-screen read also passes S_RD_WAIT,
// a print that scrolls S_SCROLL and S_BLANK, and a clear S_CLEAR. S_DONE
// waits for a free output register, where the result is then registered.
// The cell RAM has one write and one read port, so scroll and clear walk it
// one cell per cycle through a single address counter. The sequencer holds one
// item at a time; o_in_ready is low until its result is in the output register.
// Reset starts a clear of the whole RAM in attribute 15 with the cursor at
// zero; no input item is taken meanwhile, config writes are.
// If the receiver stalls, the result waits in the output register; one more
// item may be taken and finished up to its result, which then waits too.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tmtw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tmtw_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    logic                          r_out_valid;
    tmtw_pkg::t_out_item           r_out_item;
    logic [7:0]                    r_clear_attr;

    logic                          seq_idle;
    logic                          seq_done;
    logic                          slot_free;
    tmtw_pkg::t_ram_req            ram_req;
    tmtw_pkg::t_out_item           seq_result;
    logic [tmtw_pkg::CELL_W-1:0]   ram_rdata;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = seq_idle;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_attr <= tmtw_pkg::CLR_ATTR_RST;
        end else if (i_cfg_valid) begin
            r_clear_attr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
            r_out_item  <= seq_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    tmtw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && seq_idle),
        .i_item       (i_in_item),
        .i_clear_attr (r_clear_attr),
        .i_rdata      (ram_rdata),
        .i_slot_free  (slot_free),
        .o_idle       (seq_idle),
        .o_ram        (ram_req),
        .o_done       (seq_done),
        .o_result     (seq_result)
    );

    tmtw_ram #(
        .WIDTH (tmtw_pkg::CELL_W),
        .DEPTH (tmtw_pkg::CELL_TOTAL)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// File: design/tmtw_ram.sv
// ---------------------------------------------------------------------------
// tmtw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tmtw_seq.sv
// ---------------------------------------------------------------------------
// tmtw_seq
// Sequencer: decodes one item, steps the cursor and walks the cell RAM
// through one shared address counter for scroll, row blanking and clear.
// ---------------------------------------------------------------------------
module tmtw_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  tmtw_pkg::t_in_item        i_item,
    input  logic [7:0]                i_clear_attr,
    input  logic [tmtw_pkg::CELL_W-1:0] i_rdata,
    input  logic                      i_slot_free,
    output logic                      o_idle,
    output tmtw_pkg::t_ram_req        o_ram,
    output logic                      o_done,
    output tmtw_pkg::t_out_item       o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SCROLL,
        S_BLANK,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state                        r_state,     n_state;
    tmtw_pkg::t_in_item            r_item,      n_item;
    logic [tmtw_pkg::CUR_W-1:0]    r_cursor,    n_cursor;
    logic [tmtw_pkg::COL_W-1:0]    r_col,       n_col;
    logic [tmtw_pkg::CUR_W-1:0]    r_sweep,     n_sweep;
    logic [7:0]                    r_fill_attr, n_fill_attr;
    logic                          r_reply,     n_reply;
    logic                          r_scrolled,  n_scrolled;
    logic                          r_oor,       n_oor;
    logic [7:0]                    r_rd_char,   n_rd_char;
    logic [7:0]                    r_rd_attr,   n_rd_attr;

    logic                          on_screen;
    logic [tmtw_pkg::ADDR_W-1:0]   cell_addr;

    // widen by one bit so a full-range geometry constant still fits
    assign on_screen = ({1'b0, r_item.row} < 6'(tmtw_pkg::SCREEN_ROWS)) &&
                       ({1'b0, r_item.col} < 8'(tmtw_pkg::SCREEN_COLS));
    assign cell_addr = tmtw_pkg::ADDR_W'(r_item.row) *
                       tmtw_pkg::ADDR_W'(tmtw_pkg::SCREEN_COLS) +
                       tmtw_pkg::ADDR_W'(r_item.col);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_sweep     = r_sweep;
        n_fill_attr = r_fill_attr;
        n_reply     = r_reply;
        n_scrolled  = r_scrolled;
        n_oor       = r_oor;
        n_rd_char   = r_rd_char;
        n_rd_attr   = r_rd_attr;
        o_ram.we    = 1'b0;
        o_ram.waddr = tmtw_pkg::ADDR_W'(r_sweep);
        o_ram.wdata = '0;
        o_ram.raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item     = i_item;
                    n_reply    = 1'b0;
                    n_scrolled = 1'b0;
                    n_oor      = 1'b0;
                    n_rd_char  = '0;
                    n_rd_attr  = '0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_item.func)
                    tmtw_pkg::FUNC_PRINT: begin
                        if (r_item.char_code == tmtw_pkg::CH_NEWLINE) begin
                            n_cursor = r_cursor - tmtw_pkg::CUR_W'(r_col) +
                                       tmtw_pkg::CUR_W'(tmtw_pkg::SCREEN_COLS);
                            n_col    = '0;
                        end else if (r_item.char_code == tmtw_pkg::CH_BACKSPACE) begin
                            if (r_cursor != '0) begin
                                n_cursor    = r_cursor - tmtw_pkg::CUR_W'(1);
                                o_ram.we    = 1'b1;
                                o_ram.waddr = tmtw_pkg::ADDR_W'(n_cursor);
                                o_ram.wdata = {r_item.color, tmtw_pkg::CH_SPACE};
                                n_col = (r_col == '0) ?
                                        tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_COLS - 1) :
                                        r_col - tmtw_pkg::COL_W'(1);
                            end
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = tmtw_pkg::ADDR_W'(r_cursor);
                            o_ram.wdata = {r_item.color, r_item.char_code};
                            n_cursor    = r_cursor + tmtw_pkg::CUR_W'(1);
                            n_col = (r_col == tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_COLS - 1)) ?
                                    '0 : r_col + tmtw_pkg::COL_W'(1);
                        end
                        // ran off the last cell: scroll the screen up one row
                        if (n_cursor == tmtw_pkg::CUR_W'(tmtw_pkg::CELL_TOTAL)) begin
                            n_scrolled = 1'b1;
                            n_sweep    = '0;
                            n_state    = S_SCROLL;
                        end
                    end
                    tmtw_pkg::FUNC_PUT: begin
                        if (on_screen) begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = cell_addr;
                            o_ram.wdata = {r_item.color, r_item.char_code};
                        end else begin
                            n_oor = 1'b1;
                        end
                    end
                    tmtw_pkg::FUNC_CLEAR: begin
                        n_fill_attr = i_clear_attr;
                        n_sweep     = '0;
                        n_cursor    = '0;
                        n_col       = '0;
                        n_reply     = 1'b1;
                        n_state     = S_CLEAR;
                    end
                    tmtw_pkg::FUNC_READ: begin
                        if (on_screen) begin
                            o_ram.raddr = cell_addr;
                            n_state     = S_RD_WAIT;
                        end else begin
                            n_oor = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                n_rd_char = i_rdata[7:0];
                n_rd_attr = i_rdata[15:8];
                n_state   = S_DONE;
            end
            S_SCROLL: begin
                // read cell s+COLS while writing back the cell read last cycle
                if (r_sweep != tmtw_pkg::CUR_W'(tmtw_pkg::MOVE_CELLS)) begin
                    o_ram.raddr = tmtw_pkg::ADDR_W'(r_sweep +
                                  tmtw_pkg::CUR_W'(tmtw_pkg::SCREEN_COLS));
                end
                if (r_sweep != '0) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = tmtw_pkg::ADDR_W'(r_sweep - tmtw_pkg::CUR_W'(1));
                    o_ram.wdata = i_rdata;
                end
                if (r_sweep == tmtw_pkg::CUR_W'(tmtw_pkg::MOVE_CELLS)) begin
                    n_state = S_BLANK;
                end else begin
                    n_sweep = r_sweep + tmtw_pkg::CUR_W'(1);
                end
            end
            S_BLANK: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = {r_item.color, tmtw_pkg::CH_SPACE};
                if (r_sweep == tmtw_pkg::CUR_W'(tmtw_pkg::CELL_TOTAL - 1)) begin
                    n_cursor = tmtw_pkg::CUR_W'(tmtw_pkg::MOVE_CELLS);
                    n_col    = '0;
                    n_state  = S_DONE;
                end else begin
                    n_sweep = r_sweep + tmtw_pkg::CUR_W'(1);
                end
            end
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = {r_fill_attr, tmtw_pkg::CH_SPACE};
                if (r_sweep == tmtw_pkg::CUR_W'(tmtw_pkg::CELL_TOTAL - 1)) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end else begin
                    n_sweep = r_sweep + tmtw_pkg::CUR_W'(1);
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // power-up clear sweep in the reset attribute, no result
            r_state     <= S_CLEAR;
            r_cursor    <= '0;
            r_col       <= '0;
            r_sweep     <= '0;
            r_fill_attr <= tmtw_pkg::CLR_ATTR_RST;
            r_reply     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_sweep     <= n_sweep;
            r_fill_attr <= n_fill_attr;
            r_reply     <= n_reply;
            r_scrolled  <= n_scrolled;
            r_oor       <= n_oor;
            r_rd_char   <= n_rd_char;
            r_rd_attr   <= n_rd_attr;
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE) && i_slot_free;

    assign o_result.cursor_pos   = tmtw_pkg::POS_W'(r_cursor);
    assign o_result.read_char    = r_rd_char;
    assign o_result.read_attr    = r_rd_attr;
    assign o_result.scrolled     = r_scrolled;
    assign o_result.out_of_range = r_oor;

endmodule

// File: design/tmtw_checker.sv
// ---------------------------------------------------------------------------
// tmtw_checker
// Port-level checks on the result channel of the terminal writer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmtw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tmtw_pkg::t_out_item o_out_item
);

    logic stall;
    logic oor_seen;
    logic scroll_seen;
    logic rd_zero;
    logic at_last_row;

    assign stall       = o_out_valid && !i_out_ready;
    assign oor_seen    = o_out_valid && o_out_item.out_of_range;
    assign scroll_seen = o_out_valid && o_out_item.scrolled;
    assign rd_zero     = (o_out_item.read_char == 8'd0) && (o_out_item.read_attr == 8'd0);
    assign at_last_row = (o_out_item.cursor_pos == tmtw_pkg::POS_W'(tmtw_pkg::MOVE_CELLS));

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, stall, o_out_valid)
    `CHK_NEXT(a_out_stable, i_clk, i_rst_n, stall, $stable(o_out_item))
    `CHK_IMPLY(a_oor_zero, i_clk, i_rst_n, oor_seen, rd_zero)
    `CHK_IMPLY(a_scroll_cursor, i_clk, i_rst_n, scroll_seen, at_last_row)
    `CHK_IMPLY(a_scroll_only, i_clk, i_rst_n, scroll_seen, !o_out_item.out_of_range)

endmodule

bind text_mode_terminal_writer_core tmtw_checker u_tmtw_checker (.*);

// File: dv/text_mode_terminal_writer_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_core_tb
// Self-checking bench for the 80x25 text screen writer. A shadow screen and
// cursor predict every result item. Stimulus runs through corner cases,
// clear-attribute settings, long scrolling text and a weighted random mix,
// with random stalls on both channels, then a steady stream without stalls.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer_core_tb;

    localparam int unsigned CYCLE_LIMIT = 12_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    tmtw_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    tmtw_pkg::t_out_item o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [7:0]          i_cfg_data;

    text_mode_terminal_writer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the screen buffer, cursor and clear attribute
    logic [tmtw_pkg::CELL_W-1:0] shadow_cells [tmtw_pkg::CELL_TOTAL];
    int                          shadow_cursor;
    logic [7:0]                  shadow_clear_attr;

    tmtw_pkg::t_out_item pending_results [$];
    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned n_results;
    int unsigned n_print, n_put, n_read, n_clear, n_scroll, n_offscreen, n_cfg;
    bit          in_idle_on;
    bit          out_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic void blank_screen(logic [7:0] attr);
        int i;
        for (i = 0; i < tmtw_pkg::CELL_TOTAL; i++)
            shadow_cells[i] = {attr, tmtw_pkg::CH_SPACE};
        shadow_cursor = 0;
    endfunction

    // updates the shadow state for one command and returns its result
    function automatic tmtw_pkg::t_out_item apply_cmd(tmtw_pkg::t_in_item it);
        tmtw_pkg::t_out_item r;
        int                  idx;
        int                  i;
        bit                  on_screen;
        r = '0;
        on_screen = (it.row < tmtw_pkg::SCREEN_ROWS) && (it.col < tmtw_pkg::SCREEN_COLS);
        idx = int'(it.row) * tmtw_pkg::SCREEN_COLS + int'(it.col);
        if (shadow_cursor >= tmtw_pkg::CELL_TOTAL)
            shadow_cursor = 0;
        case (it.func)
            tmtw_pkg::FUNC_PRINT: begin
                if (it.char_code == tmtw_pkg::CH_NEWLINE) begin
                    shadow_cursor = (shadow_cursor / tmtw_pkg::SCREEN_COLS + 1) *
                                    tmtw_pkg::SCREEN_COLS;
                end else if (it.char_code == tmtw_pkg::CH_BACKSPACE) begin
                    if (shadow_cursor > 0) begin
                        shadow_cursor--;
                        shadow_cells[shadow_cursor] = {it.color, tmtw_pkg::CH_SPACE};
                    end
                end else begin
                    shadow_cells[shadow_cursor] = {it.color, it.char_code};
                    shadow_cursor++;
                end
                if (shadow_cursor >= tmtw_pkg::CELL_TOTAL) begin
                    for (i = 0; i < tmtw_pkg::MOVE_CELLS; i++)
                        shadow_cells[i] = shadow_cells[i + tmtw_pkg::SCREEN_COLS];
                    for (i = tmtw_pkg::MOVE_CELLS; i < tmtw_pkg::CELL_TOTAL; i++)
                        shadow_cells[i] = {it.color, tmtw_pkg::CH_SPACE};
                    shadow_cursor = tmtw_pkg::MOVE_CELLS;
                    r.scrolled = 1'b1;
                end
            end
            tmtw_pkg::FUNC_PUT: begin
                if (on_screen)
                    shadow_cells[idx] = {it.color, it.char_code};
                else
                    r.out_of_range = 1'b1;
            end
            tmtw_pkg::FUNC_CLEAR: begin
                blank_screen(shadow_clear_attr);
            end
            default: begin
                if (on_screen) begin
                    r.read_char = shadow_cells[idx][7:0];
                    r.read_attr = shadow_cells[idx][15:8];
                end else begin
                    r.out_of_range = 1'b1;
                end
            end
        endcase
        r.cursor_pos = tmtw_pkg::POS_W'(shadow_cursor);
        return r;
    endfunction

    function automatic tmtw_pkg::t_in_item mk(logic [1:0] f, logic [7:0] ch,
                                              logic [7:0] attr, logic [4:0] r,
                                              logic [6:0] c);
        tmtw_pkg::t_in_item it;
        it.func      = f;
        it.char_code = ch;
        it.color     = attr;
        it.row       = r;
        it.col       = c;
        return it;
    endfunction

    // weighted random command; clear_weight is per mille
    function automatic tmtw_pkg::t_in_item random_cmd(int clear_weight);
        tmtw_pkg::t_in_item it;
        int                 pick;
        int                 cur_row;
        it = mk(tmtw_pkg::FUNC_PRINT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        pick = $urandom_range(0, 999);
        cur_row = shadow_cursor / tmtw_pkg::SCREEN_COLS;
        if (pick < clear_weight) begin
            it.func = tmtw_pkg::FUNC_CLEAR;
        end else if (pick < 380) begin
            it.func = tmtw_pkg::FUNC_PRINT;
        end else if (pick < 440) begin
            it.char_code = tmtw_pkg::CH_NEWLINE;
        end else if (pick < 520) begin
            it.char_code = tmtw_pkg::CH_BACKSPACE;
        end else if (pick < 700) begin
            it.func = tmtw_pkg::FUNC_PUT;
            if ($urandom_range(0, 6) != 0) begin
                it.row = 5'($urandom_range(0, tmtw_pkg::SCREEN_ROWS - 1));
                it.col = 7'($urandom_range(0, tmtw_pkg::SCREEN_COLS - 1));
            end
        end else begin
            it.func = tmtw_pkg::FUNC_READ;
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                // near the cursor, where recent text landed
                if (cur_row > 0 && $urandom_range(0, 1) == 1)
                    cur_row--;
                it.row = 5'(cur_row);
                it.col = 7'($urandom_range(0, tmtw_pkg::SCREEN_COLS - 1));
            end else if (pick < 17) begin
                it.row = 5'($urandom_range(0, tmtw_pkg::SCREEN_ROWS - 1));
                it.col = 7'($urandom_range(0, tmtw_pkg::SCREEN_COLS - 1));
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      n_results, name, got, want));
    endtask

    // sends one item; valid stays high afterwards unless the next call idles
    task automatic send_cmd(tmtw_pkg::t_in_item it);
        tmtw_pkg::t_out_item r;
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        r = apply_cmd(it);
        pending_results.push_back(r);
        case (it.func)
            tmtw_pkg::FUNC_PRINT: n_print++;
            tmtw_pkg::FUNC_PUT:   n_put++;
            tmtw_pkg::FUNC_CLEAR: n_clear++;
            default:              n_read++;
        endcase
        if (r.scrolled)
            n_scroll++;
        if (r.out_of_range)
            n_offscreen++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_clear_attr(logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_clear_attr = val;
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        tmtw_pkg::t_out_item want_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h", o_out_item));
            end else begin
                want_r = pending_results.pop_front();
                check_field("cursor_pos", 16'(o_out_item.cursor_pos),
                            16'(want_r.cursor_pos));
                check_field("read_char", 16'(o_out_item.read_char),
                            16'(want_r.read_char));
                check_field("read_attr", 16'(o_out_item.read_attr),
                            16'(want_r.read_attr));
                check_field("scrolled", 16'(o_out_item.scrolled),
                            16'(want_r.scrolled));
                check_field("out_of_range", 16'(o_out_item.out_of_range),
                            16'(want_r.out_of_range));
            end
            n_results++;
        end
    end

    // receiver stalls in bursts
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge i_clk);
        end
    end

    task automatic test_after_reset();
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'(tmtw_pkg::SCREEN_ROWS - 1),
                    7'(tmtw_pkg::SCREEN_COLS - 1)));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'hFF, 8'hFF, 5'd12, 7'd40));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'd0,
                    7'(tmtw_pkg::SCREEN_COLS - 1)));
    endtask

    task automatic test_edge_cases();
        send_cmd(mk(tmtw_pkg::FUNC_PRINT, 8'h00, 8'h00, 5'd0, 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_PRINT, 8'hFF, 8'hFF, 5'd31, 7'd127));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd1));
        send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_BACKSPACE, 8'hA5, 5'd0, 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_BACKSPACE, 8'h5A, 5'd0, 7'd0));
        // backspace with the cursor already at zero
        send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_BACKSPACE, 8'hFF, 5'd0, 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd1));
        send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_NEWLINE, 8'h3C, 5'd31, 7'd127));
        send_cmd(mk(tmtw_pkg::FUNC_PUT, 8'h5A, 8'hC3, 5'(tmtw_pkg::SCREEN_ROWS - 1),
                    7'(tmtw_pkg::SCREEN_COLS - 1)));
        send_cmd(mk(tmtw_pkg::FUNC_PUT, 8'hFF, 8'h00, 5'd0, 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_PUT, 8'h41, 8'h11, 5'(tmtw_pkg::SCREEN_ROWS), 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_PUT, 8'h42, 8'h22, 5'd0, 7'(tmtw_pkg::SCREEN_COLS)));
        send_cmd(mk(tmtw_pkg::FUNC_PUT, 8'h43, 8'h33, 5'd31, 7'd127));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'(tmtw_pkg::SCREEN_ROWS - 1),
                    7'(tmtw_pkg::SCREEN_COLS - 1)));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'(tmtw_pkg::SCREEN_ROWS), 7'd0));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'd31, 7'd127));
        send_cmd(mk(tmtw_pkg::FUNC_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127));
        send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'(tmtw_pkg::SCREEN_ROWS - 1),
                    7'(tmtw_pkg::SCREEN_COLS - 1)));
    endtask

    task automatic test_clear_attribute();
        logic [7:0] settings [4];
        int         k;
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom_range(0, 255));
        settings[3] = 8'($urandom_range(0, 255));
        for (k = 0; k < 4; k++) begin
            wait_idle();
            write_clear_attr(settings[k]);
            send_cmd(mk(tmtw_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                        7'($urandom_range(0, 127))));
            send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00,
                        5'($urandom_range(0, tmtw_pkg::SCREEN_ROWS - 1)),
                        7'($urandom_range(0, tmtw_pkg::SCREEN_COLS - 1))));
            send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_BACKSPACE,
                        8'($urandom_range(0, 255)), 5'd0, 7'd0));
            send_cmd(mk(tmtw_pkg::FUNC_PRINT, 8'($urandom_range(33, 126)),
                        8'($urandom_range(0, 255)), 5'd0, 7'd0));
            send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00, 5'(tmtw_pkg::SCREEN_ROWS - 1),
                        7'(tmtw_pkg::SCREEN_COLS - 1)));
        end
    endtask

    // lines of text long enough to run the screen off the bottom many times
    task automatic test_scroll_region();
        int line;
        int k;
        send_cmd(mk(tmtw_pkg::FUNC_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
        for (line = 0; line < 60; line++) begin
            repeat ($urandom_range(0, 6))
                send_cmd(mk(tmtw_pkg::FUNC_PRINT, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                            7'($urandom_range(0, 127))));
            send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_NEWLINE,
                        8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                        7'($urandom_range(0, 127))));
            send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00,
                        5'(tmtw_pkg::SCREEN_ROWS - 1 - $urandom_range(0, 3)),
                        7'($urandom_range(0, tmtw_pkg::SCREEN_COLS - 1))));
            if (line == 40) begin
                // run past the end of the last row without a newline
                for (k = 0; k < tmtw_pkg::SCREEN_COLS + 5; k++)
                    send_cmd(mk(tmtw_pkg::FUNC_PRINT, 8'($urandom_range(33, 126)),
                                8'($urandom_range(0, 255)), 5'd0, 7'd0));
                // backspace across the row boundary
                repeat (8)
                    send_cmd(mk(tmtw_pkg::FUNC_PRINT, tmtw_pkg::CH_BACKSPACE,
                                8'($urandom_range(0, 255)), 5'd0, 7'd0));
                for (k = 0; k < 4; k++)
                    send_cmd(mk(tmtw_pkg::FUNC_READ, 8'h00, 8'h00,
                                5'(tmtw_pkg::SCREEN_ROWS - 2 + k / 2),
                                7'(tmtw_pkg::SCREEN_COLS - 4 + k)));
            end
        end
    endtask

    task automatic test_random_mix(int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n > 0 && n % 250 == 0) begin
                wait_idle();
                write_clear_attr(8'($urandom_range(0, 255)));
            end else if (n == 375) begin
                wait_idle();
            end
            send_cmd(random_cmd(4));
        end
    endtask

    task automatic test_steady_stream(int count);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (count)
            send_cmd(random_cmd(4));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        shadow_clear_attr = tmtw_pkg::CLR_ATTR_RST;
        blank_screen(tmtw_pkg::CLR_ATTR_RST);

        test_after_reset();
        test_edge_cases();
        test_clear_attribute();
        test_scroll_region();
        test_random_mix(750);
        test_steady_stream(150);

        wait_idle();
        // long enough for a stray scroll or clear to surface
        repeat (tmtw_pkg::CELL_TOTAL + 100) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d prints, %0d puts, %0d reads, %0d clears (%0d results)",
                 n_print, n_put, n_read, n_clear, n_results);
        $display("with %0d scrolls, %0d off-screen accesses, %0d clear-attribute writes",
                 n_scroll, n_offscreen, n_cfg);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/tmtw_pkg.sv
design/tmtw_ram.sv
design/tmtw_seq.sv
design/text_mode_terminal_writer_core.sv
design/tmtw_checker.sv
dv/text_mode_terminal_writer_core_tb.sv
